// ===== src/course_heading_validity_qualifier_macros.svh =====
// ----------------------------------------------------------------------------
// course heading validity qualifier assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COURSE_HEADING_VALIDITY_QUALIFIER_MACROS_SVH
`define COURSE_HEADING_VALIDITY_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CHVQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chvq check failed");
// next-cycle implication
`define CHVQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chvq check failed");
`else
`define CHVQ_ASSERT_IMPL(lbl, ante, cons)
`define CHVQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/chvq_pkg.sv =====
// ----------------------------------------------------------------------------
// chvq_pkg
// shared types, widths and constants of the course heading validity qualifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chvq_pkg;

  localparam int HIST_DEPTH = 10;
  localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  localparam int COURSE_W   = 12;
  localparam int SPEED_W    = 16;
  localparam int SPREAD_W   = 11;
  localparam int DWELL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [COURSE_W-1:0] FULL_TURN  = COURSE_W'(3600);
  localparam logic [COURSE_W-1:0] FOLD_POINT = COURSE_W'(1800);

  localparam logic [SPEED_W-1:0]  MIN_SPEED_RST     = SPEED_W'(500);
  localparam logic [SPREAD_W-1:0] SPREAD_LIMIT_RST  = SPREAD_W'(150);
  localparam logic [DWELL_W-1:0]  VALID_DWELL_RST   = DWELL_W'(10);
  localparam logic [DWELL_W-1:0]  INVALID_DWELL_RST = DWELL_W'(20);
  localparam logic [DWELL_W-1:0]  COUNT_MAX         = {DWELL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_DWELL   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_DWELL = CFG_IDX_W'(3);

  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FOLD,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load_sample;
    logic              restart;
    logic              scan_en;
    logic [SLOT_W-1:0] scan_idx;
    logic              fold;
    logic              update;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== src/chvq_ctrl.sv =====
// ----------------------------------------------------------------------------
// chvq_ctrl
// sequencer: accept or restart, history scan, fold, counter update, result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "course_heading_validity_qualifier_macros.svh"

module chvq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_func,
  input  chvq_pkg::status_t status,
  output chvq_pkg::cmd_t    cmd
);
  import chvq_pkg::*;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic              scan_last;

  assign scan_last = (scan_idx_r == SLOT_W'(HIST_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.scan_idx = scan_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_func == FUNC_RESTART) begin
            cmd.restart = 1'b1;
            state_nxt   = ST_EMIT;
          end else begin
            cmd.load_sample = 1'b1;
            scan_idx_nxt    = '0;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (scan_last) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_FOLD;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `CHVQ_ASSERT_IMPL(a_scan_idx_range, 1'b1, scan_idx_r <= SLOT_W'(HIST_DEPTH - 1))
  `CHVQ_ASSERT_NEXT(a_scan_to_fold, (state_r == ST_SCAN) && scan_last, state_r == ST_FOLD)

endmodule

// ===== src/chvq_dp.sv =====
// ----------------------------------------------------------------------------
// chvq_dp
// course ring, min/max walk, spread fold, dwell counters, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "course_heading_validity_qualifier_macros.svh"

module chvq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chvq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chvq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [chvq_pkg::COURSE_W-1:0]       in_course,
  input  logic [chvq_pkg::SPEED_W-1:0]        in_speed,
  input  chvq_pkg::cmd_t                      cmd,
  output chvq_pkg::status_t                   status,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [chvq_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import chvq_pkg::*;

  // configuration
  logic [SPEED_W-1:0]  min_speed_r;
  logic [SPREAD_W-1:0] spread_limit_r;
  logic [DWELL_W-1:0]  valid_dwell_r;
  logic [DWELL_W-1:0]  invalid_dwell_r;

  // history and walk
  logic [COURSE_W-1:0] hist_r [HIST_DEPTH];
  logic [SLOT_W-1:0]   slot_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [COURSE_W-1:0] lo_r, hi_r;
  logic [SPREAD_W-1:0] spread_r, spread_nxt;

  // qualifier state
  logic [DWELL_W-1:0]  good_cnt_r, good_cnt_nxt;
  logic [DWELL_W-1:0]  bad_cnt_r, bad_cnt_nxt;
  logic                valid_r, valid_nxt;

  // result register
  logic                  out_valid_r;
  logic [SPREAD_W:0]     out_data_r;
  logic [SPREAD_W:0]     result_word;

  logic [COURSE_W-1:0] entry;
  logic [COURSE_W-1:0] raw_diff;
  logic [COURSE_W-1:0] raw_mod;
  logic                good;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r     <= MIN_SPEED_RST;
      spread_limit_r  <= SPREAD_LIMIT_RST;
      valid_dwell_r   <= VALID_DWELL_RST;
      invalid_dwell_r <= INVALID_DWELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SPEED:     min_speed_r     <= cfg_data;
        CFG_SPREAD_LIMIT:  spread_limit_r  <= cfg_data[SPREAD_W-1:0];
        CFG_VALID_DWELL:   valid_dwell_r   <= cfg_data[DWELL_W-1:0];
        CFG_INVALID_DWELL: invalid_dwell_r <= cfg_data[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // ring of recent courses
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      slot_r <= '0;
    end else if (cmd.load_sample) begin
      hist_r[slot_r] <= in_course;
      if (slot_r == SLOT_W'(HIST_DEPTH - 1)) begin
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  assign entry = hist_r[cmd.scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      speed_r <= in_speed;
    end
    if (cmd.scan_en) begin
      if (cmd.scan_idx == '0) begin
        lo_r <= entry;
        hi_r <= entry;
      end else begin
        if (entry < lo_r) begin
          lo_r <= entry;
        end
        if (entry > hi_r) begin
          hi_r <= entry;
        end
      end
    end
  end

  // spread folded across north
  always_comb begin
    raw_diff = hi_r - lo_r;
    raw_mod  = (raw_diff >= FULL_TURN) ? (raw_diff - FULL_TURN) : raw_diff;
    if (raw_mod > FOLD_POINT) begin
      spread_nxt = SPREAD_W'(FULL_TURN - raw_mod);
    end else begin
      spread_nxt = raw_mod[SPREAD_W-1:0];
    end
  end

  // dwell and hysteresis
  always_comb begin
    good         = (speed_r >= min_speed_r) && (spread_r < spread_limit_r);
    good_cnt_nxt = good_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    valid_nxt    = valid_r;
    if (good) begin
      bad_cnt_nxt = '0;
      if (good_cnt_r < valid_dwell_r) begin
        good_cnt_nxt = good_cnt_r + 1'b1;
      end
    end else if (valid_r) begin
      if (bad_cnt_r != COUNT_MAX) begin
        bad_cnt_nxt = bad_cnt_r + 1'b1;
      end
      if (bad_cnt_nxt >= invalid_dwell_r) begin
        good_cnt_nxt = '0;
        valid_nxt    = 1'b0;
      end
    end else begin
      good_cnt_nxt = '0;
    end
    if (!valid_nxt) begin
      valid_nxt = (good_cnt_nxt >= valid_dwell_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      good_cnt_r <= '0;
      bad_cnt_r  <= '0;
      valid_r    <= 1'b0;
      spread_r   <= '0;
    end else begin
      if (cmd.fold) begin
        spread_r <= spread_nxt;
      end
      if (cmd.update) begin
        good_cnt_r <= good_cnt_nxt;
        bad_cnt_r  <= bad_cnt_nxt;
        valid_r    <= valid_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign result_word = {spread_r, valid_r};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= result_word;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = OUT_DATA_W'(out_data_r);

  `CHVQ_ASSERT_IMPL(a_spread_range, 1'b1, spread_r <= SPREAD_W'(FOLD_POINT))
  `CHVQ_ASSERT_NEXT(a_restart_clears, cmd.restart, !valid_r && (spread_r == '0))
  `CHVQ_ASSERT_NEXT(a_emit_loads, cmd.emit, out_valid_r && (out_data_r == $past(result_word)))

endmodule

// ===== src/course_heading_validity_qualifier.sv =====
// ----------------------------------------------------------------------------
// course_heading_validity_qualifier
// decides whether gps course over ground can be trusted as heading
// ----------------------------------------------------------------------------
//  channel | dir | signals                              | contents
//  in      | in  | in_tvalid in_tready in_tdata in_tuser | course, ground speed; func
//  out     | out | out_tvalid out_tready out_tdata      | heading valid, course spread
//  cfg     | in  | cfg_we cfg_index cfg_data             | four qualifier registers
//
//  an item is taken only in idle, then passes accept, a walk over all 10 history
//  entries for min/max, fold, counter update, hand-off to the output register;
//  a restart item goes from accept straight to the hand-off
//  the output register frees the input side: a new item is taken while a
//  result still waits; a result waiting past the next one stalls the sequencer
//  synchronous active-low reset restores registers, clears ring and counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module course_heading_validity_qualifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [chvq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chvq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [chvq_pkg::IN_DATA_W-1:0]      in_tdata,   // course[11:0], ground_speed[27:12]
  input  logic                                in_tuser,   // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [chvq_pkg::OUT_DATA_W-1:0]     out_tdata   // heading_valid[0], course_spread[11:1]
);
  import chvq_pkg::*;

  cmd_t    cmd;
  status_t status;

  chvq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  chvq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_course  (in_tdata[COURSE_W-1:0]),
    .in_speed   (in_tdata[COURSE_W+SPEED_W-1:COURSE_W]),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== bench/course_heading_validity_qualifier_test.sv =====
// ----------------------------------------------------------------------------
// course_heading_validity_qualifier_test
// self-checking bench: a directed table of gps fixes, then random traffic in
// phases of several threshold settings; fixed rows checked by typed verdict,
// others by an in-bench model of course ring, folded spread, dwell counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module course_heading_validity_qualifier_test;
  import chvq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PROBES    = 24;

  typedef struct packed {
    logic                restart;
    logic [COURSE_W-1:0] course;
    logic [SPEED_W-1:0]  speed;
    logic                fixed;
    logic                hv;
    logic [SPREAD_W-1:0] spread;
  } probe_row_t;

  typedef struct packed {
    logic                hv;
    logic [SPREAD_W-1:0] spread;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // typed expectation travelling with the fix being offered
  logic                  row_fixed = 1'b0;
  verdict_t              row_verdict = '0;

  // model state
  logic [COURSE_W-1:0]   ring [HIST_DEPTH];
  int                    slot;
  logic [DWELL_W-1:0]    good_cnt, bad_cnt;
  logic                  valid_q;
  logic [SPEED_W-1:0]    min_speed;
  logic [SPREAD_W-1:0]   spread_lim;
  logic [DWELL_W-1:0]    vdwell, idwell;

  verdict_t              verdict_q [$];
  int                    errors = 0;
  int                    cycles = 0;
  int                    stall_left = 0;
  logic                  idle_on = 1'b1;
  int                    cur_min = 500;

  probe_row_t probes [N_PROBES] = '{
    '{1'b0, 12'd0,    16'd0,     1'b1, 1'b0, 11'd0},
    '{1'b0, 12'd3599, 16'd65535, 1'b0, 1'b0, 11'd0},
    '{1'b1, 12'd0,    16'd0,     1'b1, 1'b0, 11'd0},
    '{1'b0, 12'd3599, 16'd65535, 1'b1, 1'b0, 11'd1},
    '{1'b1, 12'd0,    16'd0,     1'b1, 1'b0, 11'd0},
    '{1'b0, 12'd4095, 16'd65535, 1'b1, 1'b0, 11'd495},
    '{1'b1, 12'd0,    16'd0,     1'b1, 1'b0, 11'd0},
    '{1'b0, 12'd1800, 16'd500,   1'b1, 1'b0, 11'd1800},
    '{1'b0, 12'd1801, 16'd499,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd3600, 16'd0,     1'b0, 1'b0, 11'd0},
    '{1'b1, 12'd0,    16'd0,     1'b1, 1'b0, 11'd0},
    '{1'b0, 12'd50,   16'd500,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd51,   16'd501,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd52,   16'd65535, 1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd53,   16'd1000,  1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd54,   16'd32768, 1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd55,   16'd600,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd56,   16'd700,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd57,   16'd800,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd58,   16'd900,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd59,   16'd500,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd2000, 16'd500,   1'b0, 1'b0, 11'd0},
    '{1'b0, 12'd55,   16'd499,   1'b0, 1'b0, 11'd0},
    '{1'b1, 12'd4095, 16'd65535, 1'b1, 1'b0, 11'd0}
  };

  course_heading_validity_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output side stalls in bursts of random length while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic clear_track();
    for (int i = 0; i < HIST_DEPTH; i++) ring[i] = '0;
    slot = 0;
    good_cnt = '0;
    bad_cnt = '0;
    valid_q = 1'b0;
  endtask

  task automatic qualify_fix(input logic restart, input logic [COURSE_W-1:0] course,
                             input logic [SPEED_W-1:0] speed, output verdict_t v);
    int  lo, hi, raw;
    bit  good;
    if (restart) begin
      clear_track();
      v = '0;
    end else begin
      ring[slot] = course;
      slot = (slot == HIST_DEPTH - 1) ? 0 : slot + 1;
      lo = ring[0];
      hi = ring[0];
      for (int i = 1; i < HIST_DEPTH; i++) begin
        if (ring[i] < lo) lo = ring[i];
        if (ring[i] > hi) hi = ring[i];
      end
      raw = (hi - lo) % int'(FULL_TURN);
      if (raw > int'(FOLD_POINT)) raw = int'(FULL_TURN) - raw;
      good = (speed >= min_speed) && (raw < int'(spread_lim));
      if (good) begin
        bad_cnt = '0;
        if (good_cnt < vdwell) good_cnt = good_cnt + 1'b1;
      end else if (valid_q) begin
        if (bad_cnt != COUNT_MAX) bad_cnt = bad_cnt + 1'b1;
        if (bad_cnt >= idwell) begin
          good_cnt = '0;
          valid_q = 1'b0;
        end
      end else begin
        good_cnt = '0;
      end
      if (!valid_q) valid_q = (good_cnt >= vdwell);
      v.hv = valid_q;
      v.spread = SPREAD_W'(raw);
    end
  endtask

  // model follows every accepted transaction and register write
  always @(posedge clk) begin
    verdict_t pv, ev;
    if (!rst_n) begin
      clear_track();
      min_speed = MIN_SPEED_RST;
      spread_lim = SPREAD_LIMIT_RST;
      vdwell = VALID_DWELL_RST;
      idwell = INVALID_DWELL_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result: actual valid %0d spread %0d", $time,
                   out_tdata[0], out_tdata[11:1]);
          errors++;
        end else begin
          ev = verdict_q.pop_front();
          if (out_tdata[0] !== ev.hv) begin
            $display("%0t heading_valid: expected %0d actual %0d", $time, ev.hv,
                     out_tdata[0]);
            errors++;
          end
          if (out_tdata[11:1] !== ev.spread) begin
            $display("%0t course_spread: expected %0d actual %0d", $time, ev.spread,
                     out_tdata[11:1]);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_SPEED:     min_speed = cfg_data;
          CFG_SPREAD_LIMIT:  spread_lim = cfg_data[SPREAD_W-1:0];
          CFG_VALID_DWELL:   vdwell = cfg_data[DWELL_W-1:0];
          CFG_INVALID_DWELL: idwell = cfg_data[DWELL_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        qualify_fix(in_tuser, in_tdata[COURSE_W-1:0], in_tdata[COURSE_W +: SPEED_W], pv);
        verdict_q.push_back(row_fixed ? row_verdict : pv);
      end
    end
  end

  // offer one fix; returns at the edge where it is taken
  task automatic offer_fix(input logic restart, input logic [COURSE_W-1:0] course,
                           input logic [SPEED_W-1:0] speed, input logic fixed,
                           input verdict_t typed);
    logic rdy;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser    <= restart;
    in_tdata    <= {{(IN_DATA_W - COURSE_W - SPEED_W){1'b0}}, speed, course};
    row_fixed   <= fixed;
    row_verdict <= typed;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int ms, input int sl, input int vd, input int id);
    drain();
    write_reg(CFG_MIN_SPEED, ms);
    write_reg(CFG_SPREAD_LIMIT, sl);
    write_reg(CFG_VALID_DWELL, vd);
    write_reg(CFG_INVALID_DWELL, id);
    cur_min = ms;
  endtask

  function automatic logic [SPEED_W-1:0] moving_speed();
    int s;
    s = cur_min + $urandom_range(0, 3000);
    return (s > 65535) ? 16'hFFFF : SPEED_W'(s);
  endfunction

  // mostly steady tracks with jitter, plus restarts and raw noise
  task automatic fly_tracks(input int count);
    int done, kind, center, len, jit, off, c;
    logic [SPEED_W-1:0] sp;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        center = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3599);
        len = $urandom_range(8, 40);
        jit = $urandom_range(0, 60);
        for (int k = 0; k < len; k++) begin
          off = int'($urandom_range(0, 2 * jit)) - jit;
          c = (center + off + 3600) % 3600;
          sp = moving_speed();
          if ($urandom_range(0, 11) == 0) begin
            if (cur_min > 0 && $urandom_range(0, 1) == 0)
              sp = SPEED_W'($urandom_range(0, cur_min - 1));
            else c = $urandom_range(0, 3599);
          end
          offer_fix(1'b0, COURSE_W'(c), sp, 1'b0, '0);
        end
        done += len;
      end else if (kind < 17) begin
        offer_fix(1'b1, COURSE_W'($urandom), SPEED_W'($urandom), 1'b0, '0);
        done++;
      end else begin
        offer_fix(1'b0, COURSE_W'($urandom), SPEED_W'($urandom), 1'b0, '0);
        done++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i])
      offer_fix(probes[i].restart, probes[i].course, probes[i].speed, probes[i].fixed,
                '{probes[i].hv, probes[i].spread});

    set_thresholds(0, 1800, 1, 1);
    fly_tracks(250);
    set_thresholds(65535, 0, 255, 255);
    fly_tracks(100);
    set_thresholds(0, 0, 0, 0);
    fly_tracks(100);
    for (int p = 0; p < 4; p++) begin
      set_thresholds($urandom_range(300, 800), $urandom_range(50, 300),
                     $urandom_range(2, 12), $urandom_range(2, 12));
      fly_tracks(210);
    end
    set_thresholds(0, 1800, 255, 1);
    fly_tracks(60);
    set_thresholds(500, 150, 10, 20);
    idle_on = 1'b0;
    fly_tracks(250);

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
